/* src/mph_pkg.sv */
// Shared constants, register indexes and controller/datapath handshake types for the PID drive.
package mph_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_OUTPUTS  = 3'd4;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_MEAS = 2'd1;
    localparam logic [1:0] MODE_FWD  = 2'd2;
    localparam logic [1:0] MODE_REV  = 2'd3;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic signed [16:0] ERR_WINDOW_HI = 17'sd20;
    localparam logic signed [16:0] ERR_WINDOW_LO = -17'sd20;
    localparam logic signed [33:0] INTEG_LIMIT_POS = 34'sd2147483648;
    localparam logic signed [33:0] INTEG_LIMIT_NEG = -34'sd2147483648;
    localparam logic signed [42:0] TOTAL_MAX_FX = 43'sd256000;
    localparam logic [9:0] TOTAL_MAX_INT = 10'd1000;

    // floor(23*x/1000) for x up to 1000 equals (x * RECIP_23) >> RECIP_SHIFT.
    localparam logic [22:0] RECIP_23    = 23'd6174028;
    localparam int          RECIP_SHIFT = 28;

    // Dividend of the derivative division: 30-bit product with 8 fraction bits.
    localparam int DIV_BITS  = 38;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic calc_err;
        logic mul;
        logic intg;
        logic sum;
        logic clamp;
        logic scale;
        logic map;
        logic push;
    } mph_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic item_drive;
        logic due;
        logic div_done;
        logic out_free;
    } mph_stat_t;

endpackage

/* src/mph_if.sv */
// Request and result channel interfaces of the PID drive.
interface mph_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;

    modport source (output valid, output mode, output setpoint, output measured, input ready);
    modport sink   (input valid, input mode, input setpoint, input measured, output ready);
endinterface

interface mph_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] duty_a;
    logic [9:0] duty_b;
    logic       recomputed;

    modport source (output valid, output duty_a, output duty_b, output recomputed, input ready);
    modport sink   (input valid, input duty_a, input duty_b, input recomputed, output ready);
endinterface

/* src/motor_pid_hbridge_drive_core.sv */
// Top level of the PID speed loop that drives an H-bridge through two PWM duties.
// Tick and measurement requests are taken one per cycle while the controller is idle
// and give no result. A drive request gives one result: when no update is due the
// controller goes straight to its done state and pushes the held duty into the result
// register once that is free, and the next request can then be taken; when the elapsed
// milliseconds exceed the update period the PID recomputes before the next request can
// be taken, a span set mainly by the 38-step restoring divider that scales the
// derivative term by the period. A finished result waits in an output register, so
// ticks and measurements are still taken while it is unread. Configuration writes are
// registered and are meant to be made while the block is idle.
module motor_pid_hbridge_drive_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mph_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [mph_pkg::CFG_DATA_W-1:0] cfg_data,
    mph_item_if.sink                       item,
    mph_result_if.source                   result
);

    mph_pkg::mph_cmd_t  cmd;
    mph_pkg::mph_stat_t stat;

    mph_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mph_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item),
        .result   (result),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* src/mph_div.sv */
// Restoring divider, one quotient bit per cycle, for the derivative term.
module mph_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mph_pkg::DIV_BITS-1:0]  dividend,
    input  logic [15:0]                   divisor,
    output logic [mph_pkg::DIV_BITS-1:0]  quotient,
    output logic                          done
);

    logic [mph_pkg::DIV_BITS-1:0]  num_reg, num_next;
    logic [15:0]                   rem_reg, rem_next;
    logic [mph_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [17:0]                   trial;
    logic                          ge;

    always_comb
    begin
        trial = {1'b0, rem_reg, num_reg[mph_pkg::DIV_BITS-1]} - {2'b00, divisor};
        ge    = !trial[17];
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[mph_pkg::DIV_BITS-2:0], ge};
            rem_next = ge ? trial[15:0] : {rem_reg[14:0], num_reg[mph_pkg::DIV_BITS-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mph_pkg::DIV_CNT_W'(mph_pkg::DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

/* src/mph_ctrl.sv */
// Sequencing state machine of the PID drive.
module mph_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  mph_pkg::mph_stat_t stat,
    output mph_pkg::mph_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ERR   = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_INTG  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_SUM   = 9'b000100000,
        S_CLAMP = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   map_pending_reg, map_pending_next;

    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        map_pending_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.item_drive)
                        state_next = stat.due ? S_ERR : S_DONE;
                end
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_INTG;
            end
            S_INTG:
            begin
                cmd.intg   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale        = 1'b1;
                map_pending_next = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                // After a recompute, the scaled duty is first folded into the last duty here, and only then pushed.
                if (map_pending_reg)
                    cmd.map = 1'b1;
                else if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            map_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            map_pending_reg <= map_pending_next;
        end
    end

endmodule

/* src/mph_dpath.sv */
// PID datapath: configuration, loop state, arithmetic stages and the result register.
module mph_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mph_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [mph_pkg::CFG_DATA_W-1:0]   cfg_data,
    mph_item_if.sink                         item,
    mph_result_if.source                     result,
    input  mph_pkg::mph_cmd_t                cmd,
    output mph_pkg::mph_stat_t               stat
);

    // Configuration
    logic [11:0] kp_reg, ki_reg, kd_reg;
    logic [15:0] period_reg;
    logic        swap_reg;

    // Loop state
    logic signed [15:0] meas_reg;
    logic signed [16:0] prev_err_reg;
    logic signed [32:0] integ_reg, integ_next;
    logic [16:0]        elapsed_reg, elapsed_next;
    logic [9:0]         last_duty_reg;

    // Per-request working registers
    logic signed [15:0] sp_reg;
    logic               fwd_reg;
    logic               rec_reg;
    logic signed [16:0] err_reg;
    logic signed [29:0] p_reg;
    logic signed [29:0] iprod_reg;
    logic               inwin_reg;
    logic               dneg_reg;
    logic [29:0]        kdm_reg;
    logic signed [42:0] total_reg, total_next;
    logic [9:0]         x_reg, x_next;
    logic [32:0]        scale_reg;

    // Result register
    logic       res_valid_reg;
    logic [9:0] duty_a_reg, duty_b_reg;
    logic       res_rec_reg;

    logic [15:0]                  per_eff;
    logic                         due;
    logic signed [17:0]           diff;
    logic [17:0]                  dmag;
    logic signed [33:0]           isum;
    logic [mph_pkg::DIV_BITS-1:0] quot;
    logic                         div_done;
    logic signed [42:0]           p_ext, d_ext, i_ext;
    logic                         to_a;

    assign per_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign due     = elapsed_reg > {1'b0, per_eff};

    assign item.ready = cmd.in_ready;

    assign stat.item_valid = item.valid;
    assign stat.item_drive = (item.mode == mph_pkg::MODE_FWD) || (item.mode == mph_pkg::MODE_REV);
    assign stat.due        = due;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !res_valid_reg || result.ready;

    mph_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.intg),
        .dividend ({kdm_reg, 8'd0}),
        .divisor  (per_eff),
        .quotient (quot),
        .done     (div_done)
    );

    always_comb
    begin
        diff = 18'(err_reg) - 18'(prev_err_reg);
        dmag = diff[17] ? 18'(-diff) : 18'(diff);
    end

    always_comb
    begin
        isum = 34'(integ_reg) + 34'(iprod_reg);
        if (!inwin_reg)
            integ_next = '0;
        else if (isum > mph_pkg::INTEG_LIMIT_POS)
            integ_next = 33'(mph_pkg::INTEG_LIMIT_POS);
        else if (isum < mph_pkg::INTEG_LIMIT_NEG)
            integ_next = 33'(mph_pkg::INTEG_LIMIT_NEG);
        else
            integ_next = 33'(isum);
    end

    always_comb
    begin
        p_ext = 43'(p_reg) <<< 8;
        i_ext = 43'(integ_reg) <<< 8;
        d_ext = $signed({5'd0, quot});
        if (dneg_reg)
            d_ext = -d_ext;
        total_next = p_ext + d_ext + i_ext;
    end

    always_comb
    begin
        if (total_reg < 0)
            x_next = '0;
        else if (total_reg > mph_pkg::TOTAL_MAX_FX)
            x_next = mph_pkg::TOTAL_MAX_INT;
        else
            x_next = total_reg[17:8];
    end

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (cmd.accept && item.mode == mph_pkg::MODE_TICK)
        begin
            if (elapsed_reg != mph_pkg::ELAPSED_MAX)
                elapsed_next = elapsed_reg + 17'd1;
        end
        else if (cmd.accept && stat.item_drive && due)
            elapsed_next = '0;
    end

    assign to_a = (fwd_reg == swap_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            period_reg    <= 16'd1;
            swap_reg      <= 1'b1;
            meas_reg      <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            elapsed_reg   <= '0;
            last_duty_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    mph_pkg::REG_PROP_GAIN:     kp_reg     <= cfg_data[11:0];
                    mph_pkg::REG_INTEG_GAIN:    ki_reg     <= cfg_data[11:0];
                    mph_pkg::REG_DERIV_GAIN:    kd_reg     <= cfg_data[11:0];
                    mph_pkg::REG_UPDATE_PERIOD: period_reg <= cfg_data[15:0];
                    mph_pkg::REG_SWAP_OUTPUTS:  swap_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            elapsed_reg <= elapsed_next;
            if (cmd.accept && item.mode == mph_pkg::MODE_MEAS)
                meas_reg <= item.measured;
            if (cmd.mul)
                prev_err_reg <= err_reg;
            if (cmd.intg)
                integ_reg <= integ_next;
            if (cmd.map)
                last_duty_reg <= x_reg + 10'(scale_reg[32:mph_pkg::RECIP_SHIFT]);
            if (cmd.push)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sp_reg  <= item.setpoint;
            fwd_reg <= (item.mode == mph_pkg::MODE_FWD);
            rec_reg <= due;
        end
        if (cmd.calc_err)
            err_reg <= 17'(sp_reg) - 17'(meas_reg);
        if (cmd.mul)
        begin
            p_reg     <= $signed({1'b0, kp_reg}) * err_reg;
            iprod_reg <= $signed({1'b0, ki_reg}) * err_reg;
            inwin_reg <= (err_reg > mph_pkg::ERR_WINDOW_LO) && (err_reg < mph_pkg::ERR_WINDOW_HI);
            kdm_reg   <= kd_reg * dmag;
            dneg_reg  <= diff[17];
        end
        if (cmd.sum)
            total_reg <= total_next;
        if (cmd.clamp)
            x_reg <= x_next;
        if (cmd.scale)
            scale_reg <= x_reg * mph_pkg::RECIP_23;
        if (cmd.push)
        begin
            duty_a_reg  <= to_a ? last_duty_reg : 10'd0;
            duty_b_reg  <= to_a ? 10'd0 : last_duty_reg;
            res_rec_reg <= rec_reg;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.duty_a     = duty_a_reg;
    assign result.duty_b     = duty_b_reg;
    assign result.recomputed = res_rec_reg;

endmodule

/* tb/mph_duty_checker.sv */
// Checker for the PID drive: mirrors the registers, predicts every duty result and compares.
module mph_duty_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mph_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [mph_pkg::CFG_DATA_W-1:0] cfg_data,
    mph_item_if                            item,
    mph_result_if                          result,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ERR_LIMIT  = 20;
    localparam longint TOTAL_SPAN = 1000;
    localparam longint DUTY_SPAN  = 1023;
    localparam longint FRAC_ONE   = 256;
    localparam longint INTEG_CAP  = 64'sd2147483648;

    typedef struct packed {
        logic [9:0] duty_a;
        logic [9:0] duty_b;
        logic       recomputed;
    } duty_result_t;

    logic [11:0]        kp;
    logic [11:0]        ki;
    logic [11:0]        kd;
    logic [15:0]        period_reg;
    logic               swap_reg;

    logic signed [15:0] speed_meas;
    logic signed [16:0] last_error;
    longint             integ_acc;
    logic [16:0]        ms_count;
    logic [9:0]         held_duty;

    duty_result_t       duty_queue[$];

    // One controller update; it also advances the loop state.
    function automatic logic [9:0] pid_recompute(input logic signed [15:0] target);
        longint per;
        longint err;
        longint p_term;
        longint d_term;
        longint total;
        per    = (period_reg == 16'd0) ? 64'sd1 : longint'(period_reg);
        err    = longint'(target) - longint'(speed_meas);
        p_term = longint'(kp) * err;
        d_term = (longint'(kd) * (err - longint'(last_error)) * FRAC_ONE) / per;
        if (err < ERR_LIMIT && err > -ERR_LIMIT)
        begin
            integ_acc = integ_acc + longint'(ki) * err;
            if (integ_acc > INTEG_CAP)
                integ_acc = INTEG_CAP;
            if (integ_acc < -INTEG_CAP)
                integ_acc = -INTEG_CAP;
        end
        else
        begin
            integ_acc = 0;
        end
        total = p_term * FRAC_ONE + d_term + integ_acc * FRAC_ONE;
        if (total < 0)
            total = 0;
        if (total > TOTAL_SPAN * FRAC_ONE)
            total = TOTAL_SPAN * FRAC_ONE;
        last_error = err[16:0];
        ms_count   = '0;
        held_duty  = 10'(((total / FRAC_ONE) * DUTY_SPAN) / TOTAL_SPAN);
        return held_duty;
    endfunction

    function automatic duty_result_t predict_duty(input logic [1:0] mode,
                                                  input logic signed [15:0] target);
        duty_result_t r;
        logic [9:0]   duty;
        logic [16:0]  per17;
        logic         to_a;
        per17 = (period_reg == 16'd0) ? 17'd1 : {1'b0, period_reg};
        if (ms_count > per17)
        begin
            duty         = pid_recompute(target);
            r.recomputed = 1'b1;
        end
        else
        begin
            duty         = held_duty;
            r.recomputed = 1'b0;
        end
        to_a     = (mode == mph_pkg::MODE_FWD) == swap_reg;
        r.duty_a = to_a ? duty : 10'd0;
        r.duty_b = to_a ? 10'd0 : duty;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input duty_result_t want,
                                 input duty_result_t got);
        if (fail_count < 10)
            $display("%0t %s: expected a=%0d b=%0d recomputed=%0b, %s",
                     $time, what, want.duty_a, want.duty_b, want.recomputed,
                     $sformatf("got a=%0d b=%0d recomputed=%0b",
                               got.duty_a, got.duty_b, got.recomputed));
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        duty_result_t got;
        duty_result_t want;
        if (!rst_n)
        begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            period_reg = 16'd1;
            swap_reg   = 1'b1;
            speed_meas = '0;
            last_error = '0;
            integ_acc  = 0;
            ms_count   = '0;
            held_duty  = '0;
            duty_queue.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    mph_pkg::REG_PROP_GAIN:     kp = cfg_data[11:0];
                    mph_pkg::REG_INTEG_GAIN:    ki = cfg_data[11:0];
                    mph_pkg::REG_DERIV_GAIN:    kd = cfg_data[11:0];
                    mph_pkg::REG_UPDATE_PERIOD: period_reg = cfg_data;
                    mph_pkg::REG_SWAP_OUTPUTS:  swap_reg = cfg_data[0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                got.duty_a     = result.duty_a;
                got.duty_b     = result.duty_b;
                got.recomputed = result.recomputed;
                if (duty_queue.size() == 0)
                begin
                    flag_mismatch("result with no drive request waiting", '0, got);
                end
                else
                begin
                    want = duty_queue.pop_front();
                    if (got !== want)
                        flag_mismatch("duty result differs", want, got);
                end
            end

            if (item.valid && item.ready)
            begin
                case (item.mode)
                    mph_pkg::MODE_TICK:
                        if (ms_count < mph_pkg::ELAPSED_MAX)
                            ms_count = ms_count + 17'd1;
                    mph_pkg::MODE_MEAS:
                        speed_meas = item.measured;
                    mph_pkg::MODE_FWD, mph_pkg::MODE_REV:
                        duty_queue.push_back(predict_duty(item.mode, item.setpoint));
                    default: ;
                endcase
            end

            pending = duty_queue.size();
        end
    end

endmodule

/* tb/motor_pid_hbridge_drive_core_tb.sv */
// Top of the PID drive testbench: clock, reset, requests, register writes and the verdict.
module motor_pid_hbridge_drive_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [mph_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [mph_pkg::CFG_DATA_W-1:0] cfg_data;

    mph_item_if   item_ch ();
    mph_result_if result_ch ();

    int fail_count;
    int pending;

    int                 sender_idle_pct    = 0;
    int                 receiver_stall_pct = 0;
    int                 hold_len           = 0;
    int                 offered            = 0;
    logic signed [15:0] sent_speed         = '0;

    motor_pid_hbridge_drive_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    mph_duty_checker duty_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("motor_pid_hbridge_drive_core_tb failed");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off when one is asked for.
    initial
    begin : result_side
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_len--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Offers one request and returns at the falling edge after it has been taken.
    // Valid is left high so that a following request can go out back to back.
    task automatic offer(input logic [1:0] mode, input logic signed [15:0] sp,
                         input logic signed [15:0] ms);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.mode     <= mode;
        item_ch.setpoint <= sp;
        item_ch.measured <= ms;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (mode == mph_pkg::MODE_MEAS)
            sent_speed = ms;
        offered++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every drive request has had its result.
    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (64) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mph_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mph_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic configure(input logic [11:0] kp, input logic [11:0] ki,
                             input logic [11:0] kd, input logic [15:0] period,
                             input logic swap);
        write_reg(mph_pkg::REG_PROP_GAIN, 16'(kp));
        write_reg(mph_pkg::REG_INTEG_GAIN, 16'(ki));
        write_reg(mph_pkg::REG_DERIV_GAIN, 16'(kd));
        write_reg(mph_pkg::REG_UPDATE_PERIOD, period);
        write_reg(mph_pkg::REG_SWAP_OUTPUTS, 16'(swap));
        // An index past the last register must change nothing.
        write_reg(mph_pkg::CFG_IDX_W'($urandom_range(mph_pkg::REG_SWAP_OUTPUTS + 1,
                                                     2 ** mph_pkg::CFG_IDX_W - 1)),
                  16'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [11:0] pick_gain();
        case ($urandom_range(3))
            0:       return 12'($urandom_range(0, 15));
            1:       return 12'($urandom_range(0, 255));
            2:       return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int                 ticks;
        int                 period_eff;
        int                 phase_start;
        logic [15:0]        period;
        logic signed [15:0] setp;
        logic signed [15:0] meas;
        bit                 pressed;
        bit                 paused;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        item_ch.valid    = 1'b0;
        item_ch.mode     = mph_pkg::MODE_TICK;
        item_ch.setpoint = '0;
        item_ch.measured = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register values after reset: no update is due at first, then a zero-gain update.
        offer(mph_pkg::MODE_FWD, 16'sd500, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_REV, -16'sd500, 16'sd0);
        drain();

        // A period of zero behaves as one; errors on both edges of the integral window.
        configure(12'd10, 12'd5, 12'd100, 16'd0, 1'b1);
        offer(mph_pkg::MODE_MEAS, 16'sd0, 16'sd100);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_FWD, 16'sd119, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_FWD, 16'sd119, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_REV, 16'sd120, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_FWD, 16'sd81, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_REV, 16'sd80, 16'sd0);
        offer(mph_pkg::MODE_MEAS, 16'sd0, -16'sd32768);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_FWD, 16'sd32767, 16'sd0);
        offer(mph_pkg::MODE_MEAS, 16'sd0, 16'sd32767);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_REV, -16'sd32768, 16'sd0);
        drain();

        // Longest period and full gains: the ticks fall short, so the last duty is held.
        configure(12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b0);
        offer(mph_pkg::MODE_MEAS, 16'sd0, 16'sd7);
        repeat (20) offer(mph_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
        offer(mph_pkg::MODE_FWD, 16'sd20, 16'sd0);
        offer(mph_pkg::MODE_TICK, 16'sd0, 16'sd0);
        offer(mph_pkg::MODE_FWD, 16'sd20, 16'sd0);
        offer(mph_pkg::MODE_REV, -16'sd3, 16'sd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            sender_idle_pct    = (phase % 4 == 1) ? 53 : (phase % 4 == 3) ? 27 : 0;
            receiver_stall_pct = (phase % 4 == 2) ? 53 : (phase % 4 == 3) ? 27 : 0;
            period     = (phase == 3) ? 16'd0 : 16'($urandom_range(1, 6));
            period_eff = (period == 16'd0) ? 1 : int'(period);
            configure(pick_gain(), pick_gain(), pick_gain(), period, 1'(phase % 2));
            phase_start = offered;
            pressed     = 1'b0;
            paused      = 1'b0;
            while (offered - phase_start < 210)
            begin
                if (!pressed && offered - phase_start >= 60)
                begin
                    pressed = 1'b1;
                    if (phase % 3 == 1)
                        hold_len = 400;
                end
                if (!paused && offered - phase_start >= 130)
                begin
                    paused = 1'b1;
                    drain();
                end
                if ($urandom_range(99) < 85)
                begin
                    // A control period: an optional measurement, ticks (mostly enough for an update), then a drive.
                    if ($urandom_range(99) < 60)
                    begin
                        if ($urandom_range(99) < 85)
                            meas = 16'(int'($urandom_range(0, 4000)) - 2000);
                        else
                            meas = 16'($urandom);
                        offer(mph_pkg::MODE_MEAS, 16'($urandom), meas);
                    end
                    if ($urandom_range(99) < 75)
                        ticks = period_eff + 1 + int'($urandom_range(0, 2));
                    else
                        ticks = int'($urandom_range(0, period_eff));
                    repeat (ticks) offer(mph_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
                    if ($urandom_range(99) < 80)
                        setp = 16'(int'(sent_speed) + int'($urandom_range(0, 60)) - 30);
                    else
                        setp = 16'($urandom);
                    offer(($urandom_range(99) < 50) ? mph_pkg::MODE_FWD : mph_pkg::MODE_REV,
                          setp, 16'($urandom));
                end
                else
                begin
                    offer(2'($urandom), 16'($urandom), 16'($urandom));
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("motor_pid_hbridge_drive_core_tb passed");
        else
            $display("motor_pid_hbridge_drive_core_tb failed");
        $finish;
    end

endmodule

/* files.f */
src/mph_pkg.sv
src/mph_if.sv
src/mph_div.sv
src/mph_ctrl.sv
src/mph_dpath.sv
src/motor_pid_hbridge_drive_core.sv
tb/mph_duty_checker.sv
tb/motor_pid_hbridge_drive_core_tb.sv
